// File: hw/rtl/tcms_pkg.sv
// ----------------------------------------------------------------------------
// tcms_pkg
// Shared types and constants for the timed channel mask scaler.
// ----------------------------------------------------------------------------
package tcms_pkg;

    localparam int unsigned DEF_MAX_FRAMES   = 64;
    localparam int unsigned DEF_MAX_CHANNELS = 512;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_MASK_WR = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_RESTART = 2'd3
    } t_func;

    localparam logic [2:0] REG_MASK_ENABLE   = 3'd0;
    localparam logic [2:0] REG_FRAME_COUNT   = 3'd1;
    localparam logic [2:0] REG_MASK_CHANNELS = 3'd2;
    localparam logic [2:0] REG_STEP_MS       = 3'd3;
    localparam logic [2:0] REG_RANGE_START   = 3'd4;
    localparam logic [2:0] REG_RANGE_LENGTH  = 3'd5;

    localparam logic [15:0] STEP_MS_RST      = 16'd50;
    localparam logic [9:0]  RANGE_LENGTH_RST = 10'd512;

    localparam logic [7:0] MASK_FILL = 8'hFF;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] frame_sel;
        logic [8:0] chan;
        logic [7:0] byte_in;
    } t_in_word;

    typedef struct packed {
        logic [8:0] chan_out;
        logic [7:0] byte_out;
        logic       was_masked;
    } t_out_word;

    typedef struct packed {
        logic        mask_enable;
        logic [6:0]  frame_count;
        logic [9:0]  mask_channels;
        logic [15:0] step_ms;
        logic [8:0]  range_start;
        logic [9:0]  range_length;
    } t_cfg;

endpackage

// File: hw/rtl/tcms_ram.sv
// ----------------------------------------------------------------------------
// tcms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcms_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tcms_regs.sv
// ----------------------------------------------------------------------------
// tcms_regs
// APB configuration registers of the mask scaler.
// ----------------------------------------------------------------------------
module tcms_regs import tcms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_enable   <= 1'b0;
            r_cfg.frame_count   <= 7'd0;
            r_cfg.mask_channels <= 10'd0;
            r_cfg.step_ms       <= STEP_MS_RST;
            r_cfg.range_start   <= 9'd0;
            r_cfg.range_length  <= RANGE_LENGTH_RST;
        end else if (wr_en) begin
            case (idx)
                REG_MASK_ENABLE:   r_cfg.mask_enable   <= pwdata[0];
                REG_FRAME_COUNT:   r_cfg.frame_count   <= pwdata[6:0];
                REG_MASK_CHANNELS: r_cfg.mask_channels <= pwdata[9:0];
                REG_STEP_MS:       r_cfg.step_ms       <= pwdata[15:0];
                REG_RANGE_START:   r_cfg.range_start   <= pwdata[8:0];
                REG_RANGE_LENGTH:  r_cfg.range_length  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MASK_ENABLE:   prdata = {31'd0, r_cfg.mask_enable};
            REG_FRAME_COUNT:   prdata = {25'd0, r_cfg.frame_count};
            REG_MASK_CHANNELS: prdata = {22'd0, r_cfg.mask_channels};
            REG_STEP_MS:       prdata = {16'd0, r_cfg.step_ms};
            REG_RANGE_START:   prdata = {23'd0, r_cfg.range_start};
            REG_RANGE_LENGTH:  prdata = {22'd0, r_cfg.range_length};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/tcms_timer.sv
// ----------------------------------------------------------------------------
// tcms_timer
// Millisecond step counter and shown-frame index.
// ----------------------------------------------------------------------------
module tcms_timer import tcms_pkg::*; #(
    parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES,
    localparam int unsigned FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int unsigned NFW = $clog2(MAX_FRAMES + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_tick,
    input  logic           i_restart,
    output logic [FIW-1:0] o_frame_index
);

    logic [15:0]    r_ms, n_ms;
    logic [FIW-1:0] r_frame, n_frame;
    logic [15:0]    step;
    logic [16:0]    ms_inc;
    logic [NFW-1:0] nf;
    logic [FIW:0]   next_frame;

    always_comb begin
        step       = (i_cfg.step_ms == 16'd0) ? 16'd1 : i_cfg.step_ms;
        // frame count clamped to the store size
        nf         = (32'(i_cfg.frame_count) > MAX_FRAMES) ? NFW'(MAX_FRAMES)
                                                           : NFW'(i_cfg.frame_count);
        ms_inc     = {1'b0, r_ms} + 17'd1;
        next_frame = {1'b0, r_frame} + {{FIW{1'b0}}, 1'b1};
        n_ms       = r_ms;
        n_frame    = r_frame;
        if (i_restart) begin
            n_ms    = 16'd0;
            n_frame = '0;
        end else if (i_tick) begin
            if (ms_inc >= {1'b0, step}) begin
                n_ms = 16'd0;
                if (nf == '0) begin
                    n_frame = '0;
                end else if (32'(next_frame) >= 32'(nf)) begin
                    n_frame = '0;
                end else begin
                    n_frame = next_frame[FIW-1:0];
                end
            end else begin
                n_ms = ms_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms    <= 16'd0;
            r_frame <= '0;
        end else begin
            r_ms    <= n_ms;
            r_frame <= n_frame;
        end
    end

    assign o_frame_index = r_frame;

endmodule

// File: hw/rtl/tcms_store.sv
// ----------------------------------------------------------------------------
// tcms_store
// Mask frame memory with the post-reset fill sweep to all ones.
// ----------------------------------------------------------------------------
module tcms_store import tcms_pkg::*; #(
    parameter int unsigned DEPTH = DEF_MAX_FRAMES * DEF_MAX_CHANNELS,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata,
    output logic          o_ready
);

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    assign ram_we    = r_clearing || i_wr;
    assign ram_waddr = r_clearing ? r_clr_addr : i_waddr;
    assign ram_wdata = r_clearing ? MASK_FILL : i_wdata;
    assign o_ready   = !r_clearing;

    tcms_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

endmodule

// File: hw/rtl/tcms_scale.sv
// ----------------------------------------------------------------------------
// tcms_scale
// Sample pipeline: mask read, multiply, divide by 255, output register.
// ----------------------------------------------------------------------------
module tcms_scale import tcms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic [8:0] i_chan,
    input  logic [7:0] i_val,
    input  logic      i_apply,
    input  logic [7:0] i_mask,
    output logic      o_adv,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic        r_s1_v, r_s1_apply;
    logic [8:0]  r_s1_chan;
    logic [7:0]  r_s1_val;
    logic        r_s2_v, r_s2_apply;
    logic [8:0]  r_s2_chan;
    logic [15:0] r_s2_prod;
    logic        r_out_v;
    t_out_word   r_out_word;
    logic        adv_out, adv2, adv1;
    logic [15:0] div_sum;
    logic [7:0]  quot;

    // each stage moves when the one after it is empty or moving
    assign adv_out = !r_out_v || i_out_ready;
    assign adv2    = !r_s2_v || adv_out;
    assign adv1    = !r_s1_v || adv2;

    // p/255 for p <= 255*255
    assign div_sum = r_s2_prod + 16'd1 + {8'd0, r_s2_prod[15:8]};
    assign quot    = div_sum[15:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= i_load;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv_out) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_load) begin
            r_s1_chan  <= i_chan;
            r_s1_val   <= i_val;
            r_s1_apply <= i_apply;
        end
        if (adv2 && r_s1_v) begin
            r_s2_chan  <= r_s1_chan;
            r_s2_apply <= r_s1_apply;
            r_s2_prod  <= r_s1_apply ? (16'(r_s1_val) * 16'(i_mask)) : {8'd0, r_s1_val};
        end
        if (adv_out && r_s2_v) begin
            r_out_word.chan_out   <= r_s2_chan;
            r_out_word.byte_out   <= r_s2_apply ? quot : r_s2_prod[7:0];
            r_out_word.was_masked <= r_s2_apply;
        end
    end

    assign o_adv       = adv1;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out_word;

endmodule

// File: hw/rtl/timed_channel_mask_scaler_top.sv
// ----------------------------------------------------------------------------
// timed_channel_mask_scaler_top
// Scales channel bytes by an animated mask held in on-chip memory.
// ----------------------------------------------------------------------------
// One input word is taken every cycle when the output side keeps up; ticks,
// mask writes and restarts finish at acceptance, and a channel sample gives
// its result word through the pipeline stages (the mask memory read runs at
// acceptance, then multiply, then divide by 255 into the output register).
// The input only stalls once all three pipeline stages hold words and the
// output register is not taken. After reset the mask memory is swept to all
// ones, one entry a cycle, over all MAX_FRAMES*MAX_CHANNELS entries (32768
// by default); no input word is taken during the sweep, while the APB
// registers are writable throughout.
// ----------------------------------------------------------------------------
module timed_channel_mask_scaler_top import tcms_pkg::*; #(
    parameter int unsigned MAX_FRAMES   = DEF_MAX_FRAMES,
    parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word
);

    localparam int unsigned DEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FIW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    t_cfg           cfg;
    logic [FIW-1:0] frame_index;
    logic           store_ready;
    logic           adv;
    logic           accept;
    logic           is_tick, is_wr, is_sample, is_restart;
    logic           wr_ok, apply;
    logic [10:0]    range_end;
    logic [AW-1:0]  waddr, raddr;
    logic [7:0]     mask_rd;

    assign o_in_ready = adv && store_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_tick    = accept && (i_in_word.func == FUNC_TICK);
    assign is_wr      = accept && (i_in_word.func == FUNC_MASK_WR);
    assign is_sample  = accept && (i_in_word.func == FUNC_SAMPLE);
    assign is_restart = accept && (i_in_word.func == FUNC_RESTART);

    assign wr_ok = (32'(i_in_word.frame_sel) < MAX_FRAMES)
                && (32'(i_in_word.chan) < MAX_CHANNELS);

    assign range_end = {2'b00, cfg.range_start} + {1'b0, cfg.range_length};

    assign apply = cfg.mask_enable
                && (cfg.frame_count != 7'd0)
                && (cfg.mask_channels != 10'd0)
                && ({1'b0, i_in_word.chan} < cfg.mask_channels)
                && (32'(i_in_word.chan) < MAX_CHANNELS)
                && (i_in_word.chan >= cfg.range_start)
                && ({2'b00, i_in_word.chan} < range_end);

    // entry address = frame * MAX_CHANNELS + channel
    assign waddr = AW'(i_in_word.frame_sel) * AW'(MAX_CHANNELS) + AW'(i_in_word.chan);
    assign raddr = AW'(frame_index) * AW'(MAX_CHANNELS) + AW'(i_in_word.chan);

    tcms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcms_timer #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_tick        (is_tick),
        .i_restart     (is_restart),
        .o_frame_index (frame_index)
    );

    tcms_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (is_wr && wr_ok),
        .i_waddr (waddr),
        .i_wdata (i_in_word.byte_in),
        .i_re    (adv),
        .i_raddr (raddr),
        .o_rdata (mask_rd),
        .o_ready (store_ready)
    );

    tcms_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (is_sample),
        .i_chan      (i_in_word.chan),
        .i_val       (i_in_word.byte_in),
        .i_apply     (apply),
        .i_mask      (mask_rd),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
